>>> rtl/lzdw_pkg.sv
// Shared types and constants for the LZSS window decompressor.
package lzdw_pkg;

  localparam int WINDOW_BITS = 13;
  localparam int WIN_DEPTH   = 1 << WINDOW_BITS;
  localparam int LEN_BITS    = 3;
  // The copy length is the length code plus three, so the final index is code plus two.
  localparam logic [3:0] LAST_INDEX_BIAS = 4'd2;

  typedef struct packed {
    logic                   lit;
    logic [7:0]             lit_byte;
    logic [WINDOW_BITS-1:0] pos;
    logic [LEN_BITS-1:0]    len_code;
  } cmd_t;

endpackage

>>> rtl/lzdw_if.sv
// Stream interfaces for the compressed input and the decompressed output.
interface lzdw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface lzdw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

>>> rtl/lzdw_front.sv
// Front end: parses flag bytes and command words into literal and copy commands.
module lzdw_front (
  input  logic          clk,
  input  logic          rst,
  lzdw_in_if.sink       upstream,
  input  logic          clearing,
  input  logic          queue_full,
  output logic          push,
  output lzdw_pkg::cmd_t push_cmd
);

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_ITEM,
    PH_CMD2
  } phase_t;

  phase_t     phase;
  logic [8:0] flag_shift;
  logic [8:0] flag_shift_next;
  logic [7:0] first_command_byte;
  logic       accept;

  assign upstream.ready  = !clearing && !queue_full;
  assign accept          = upstream.valid && upstream.ready;
  assign flag_shift_next = {1'b0, flag_shift[8:1]};

  always_comb begin
    push              = 1'b0;
    push_cmd.lit      = 1'b0;
    push_cmd.lit_byte = upstream.in_byte;
    push_cmd.pos      = {upstream.in_byte[4:0], first_command_byte};
    push_cmd.len_code = upstream.in_byte[7:5];
    if (accept) begin
      unique case (phase)
        PH_ITEM: begin
          if (flag_shift[0]) begin
            push         = 1'b1;
            push_cmd.lit = 1'b1;
          end
        end
        PH_CMD2: push = 1'b1;
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_FLAG;
      flag_shift         <= '0;
      first_command_byte <= '0;
    end else if (accept) begin
      unique case (phase)
        PH_ITEM: begin
          if (flag_shift[0]) begin
            flag_shift <= flag_shift_next;
            phase      <= (flag_shift_next <= 9'd1) ? PH_FLAG : PH_ITEM;
          end else begin
            first_command_byte <= upstream.in_byte;
            phase              <= PH_CMD2;
          end
        end
        PH_CMD2: begin
          flag_shift <= flag_shift_next;
          phase      <= (flag_shift_next <= 9'd1) ? PH_FLAG : PH_ITEM;
        end
        default: begin
          flag_shift <= {1'b1, upstream.in_byte};
          phase      <= PH_ITEM;
        end
      endcase
    end
  end

endmodule

>>> rtl/lzdw_queue.sv
// Small command queue between the parser and the copy engine.
module lzdw_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lzdw_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           head_valid,
  output lzdw_pkg::cmd_t head_cmd,
  input  logic           pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lzdw_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/lzdw_back.sv
// Back end: history window, copy sequencer and output register.
module lzdw_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  lzdw_pkg::cmd_t head_cmd,
  output logic           pop,
  output logic           clearing,
  lzdw_out_if.source     downstream
);

  localparam int WB = lzdw_pkg::WINDOW_BITS;

  logic [7:0]    window [lzdw_pkg::WIN_DEPTH];
  logic [WB-1:0] clr_addr;
  logic [WB-1:0] write_pointer;
  logic [3:0]    cnt;
  logic [WB-1:0] rd_addr;
  logic          last_issue;
  logic          issue;

  // Stage holding an issued read whose data arrives this cycle.
  logic          s1_valid;
  logic          s1_lit;
  logic [7:0]    s1_lit_byte;
  logic          s1_last;
  logic          s1_bypass;
  logic [7:0]    s1_bypass_byte;
  logic [7:0]    rd_data;
  logic [7:0]    s1_value;
  logic          advance;

  logic          out_valid;
  logic [7:0]    out_byte;
  logic          out_last;

  logic          we;
  logic [WB-1:0] wa;
  logic [7:0]    wd;

  assign s1_value = s1_lit ? s1_lit_byte : (s1_bypass ? s1_bypass_byte : rd_data);
  assign advance  = s1_valid && (!out_valid || downstream.ready);
  assign issue    = !clearing && head_valid && (!s1_valid || advance);
  assign rd_addr  = head_cmd.pos + WB'(cnt);
  assign last_issue = head_cmd.lit ||
                      (cnt == ({1'b0, head_cmd.len_code} + lzdw_pkg::LAST_INDEX_BIAS));
  assign pop      = issue && last_issue;

  assign we = clearing || advance;
  assign wa = clearing ? clr_addr : write_pointer;
  assign wd = clearing ? 8'd0 : s1_value;

  assign downstream.valid       = out_valid;
  assign downstream.out_byte    = out_byte;
  assign downstream.last_of_run = out_last;

  always_ff @(posedge clk) begin
    if (we) begin
      window[wa] <= wd;
    end
    if (issue) begin
      rd_data <= window[rd_addr];
    end
  end

  // A read that hits the byte being written this cycle takes the new byte instead.
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_lit         <= head_cmd.lit;
      s1_lit_byte    <= head_cmd.lit_byte;
      s1_last        <= last_issue;
      s1_bypass      <= advance && (write_pointer == rd_addr);
      s1_bypass_byte <= s1_value;
    end
    if (advance) begin
      out_byte <= s1_value;
      out_last <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing      <= 1'b1;
      clr_addr      <= '0;
      write_pointer <= '0;
      cnt           <= '0;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == '1) begin
          clearing <= 1'b0;
        end
      end
      if (issue) begin
        cnt <= last_issue ? 4'd0 : cnt + 4'd1;
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        write_pointer <= write_pointer + 1'b1;
        out_valid     <= 1'b1;
      end else if (downstream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/lzss_window_decompressor_top.sv
// LZSS decompressor with an 8192-byte history window.
//
// The upstream channel takes one compressed byte per transfer; the downstream
// channel gives one decompressed byte per transfer, with last_of_run set on the
// final byte that a given input byte produces. Flag bytes and first command
// bytes produce nothing; a literal produces one byte, a command 3 to 10 bytes.
// Input bytes are parsed in the front end at one per cycle while the queue has
// room, and placed as commands in a short queue; the copy engine behind it reads
// the window and emits one byte per cycle while the receiver accepts. A command
// passes through the queue, the read stage and the output register before its
// first byte appears. Sustained input rate is set by the copy engine.
// After reset the window is cleared one entry per cycle; upstream ready stays
// low during that pass. When the receiver stalls, the output register holds
// its byte, the copy engine halts, and once the queue fills upstream ready
// drops.
module lzss_window_decompressor_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  lzdw_in_if.sink    upstream,
  lzdw_out_if.source downstream
);

  logic           clearing;
  logic           queue_full;
  logic           push;
  lzdw_pkg::cmd_t push_cmd;
  logic           head_valid;
  lzdw_pkg::cmd_t head_cmd;
  logic           pop;

  lzdw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .upstream   (upstream),
    .clearing   (clearing),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  lzdw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  lzdw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .clearing   (clearing),
    .downstream (downstream)
  );

endmodule
